// ----- src/dqrm_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the deque.
package dqrm_pkg;

   // Default sizing of the entry store.
   localparam int DEF_CAPACITY    = 16;
   localparam int DEF_VALUE_WIDTH = 32;

   // Fixed field widths of the request and response words.
   localparam int OPCODE_W   = 4;
   localparam int OPERAND_W  = 32;
   localparam int POSITION_W = 4;
   localparam int RESULT_W   = 32;
   localparam int STATUS_W   = 3;
   localparam int OCC_W      = 5;

   // Request opcodes.
   localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 4'd0;
   localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 4'd1;
   localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 4'd2;
   localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 4'd3;
   localparam logic [OPCODE_W-1:0] OP_REMOVE     = 4'd4;
   localparam logic [OPCODE_W-1:0] OP_PEEK_FRONT = 4'd5;
   localparam logic [OPCODE_W-1:0] OP_PEEK_BACK  = 4'd6;
   localparam logic [OPCODE_W-1:0] OP_NTH        = 4'd7;
   localparam logic [OPCODE_W-1:0] OP_SIZE       = 4'd8;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

   // Read offset selection, counted from the front of the queue.
   localparam logic [2:0] RD_FRONT = 3'd0;
   localparam logic [2:0] RD_BACK  = 3'd1;
   localparam logic [2:0] RD_POS   = 3'd2;
   localparam logic [2:0] RD_IDX1  = 3'd3;
   localparam logic [2:0] RD_IDX2  = 3'd4;

   // Response value selection.
   localparam logic [2:0] RV_ZERO  = 3'd0;
   localparam logic [2:0] RV_DATA  = 3'd1;
   localparam logic [2:0] RV_KEY   = 3'd2;
   localparam logic [2:0] RV_ONES  = 3'd3;
   localparam logic [2:0] RV_COUNT = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                capture;
      logic                push_front;
      logic                push_back;
      logic                pop_front;
      logic                dec_count;
      logic                rd_en;
      logic [2:0]          rd_sel;
      logic                idx_clear;
      logic                idx_inc;
      logic                shift_write;
      logic                respond;
      logic [2:0]          resp_sel;
      logic [STATUS_W-1:0] resp_status;
   } dqrm_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [OPCODE_W-1:0] op;
      logic                empty;
      logic                full;
      logic                pos_ok;
      logic                match;
      logic                idx1_lt;
      logic                idx2_lt;
   } dqrm_stat_type;

endpackage

// ----- src/dqrm_datapath.sv -----
// Datapath of the deque: entry store, pointers, scan index and response registers.
module dqrm_datapath
   import dqrm_pkg::*;
#(
   parameter int CAPACITY    = DEF_CAPACITY,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  dqrm_cmd_type                cmd,
   output dqrm_stat_type               stat,
   input  logic [OPCODE_W-1:0]         req_opcode,
   input  logic signed [OPERAND_W-1:0] req_operand_value,
   input  logic [POSITION_W-1:0]       req_position,
   output logic                        rsp_strobe,
   output logic signed [RESULT_W-1:0]  rsp_result_value,
   output logic [STATUS_W-1:0]         rsp_status,
   output logic [OCC_W-1:0]            rsp_occupancy,
   output logic                        rsp_is_empty
);

   localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = (CW > POSITION_W) ? CW : POSITION_W;

   // Entry store.
   logic signed [VALUE_WIDTH-1:0] store_mem [CAPACITY];

   logic [OPCODE_W-1:0]           op_ff;
   logic signed [VALUE_WIDTH-1:0] key_ff;
   logic [POSITION_W-1:0]         pos_ff;
   logic [PW-1:0]                 front_ff, front_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [CW-1:0]                 idx_ff, idx_in;
   logic signed [VALUE_WIDTH-1:0] rd_data_ff;
   logic                          strobe_ff;
   logic signed [RESULT_W-1:0]    value_ff, value_in;
   logic [STATUS_W-1:0]           status_ff;
   logic [OCC_W-1:0]              occ_ff;
   logic                          empty_ff;

   logic [CW:0]            idx1, idx2;
   logic [CW-1:0]          rd_off;
   logic [PW-1:0]          rd_addr;
   logic [PW-1:0]          wr_addr;
   logic signed [VALUE_WIDTH-1:0] wr_data;
   logic                   wr_en;
   logic [PW-1:0]          front_dec;
   logic [PW-1:0]          front_inc;

   // Slot of an offset from the front; the sum stays below twice the capacity.
   function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] front,
                                             input logic [CW-1:0] off);
      logic [CW:0] sum;
      sum = (CW+1)'(front) + (CW+1)'(off);
      if (sum >= (CW+1)'(CAPACITY)) begin
         sum = sum - (CW+1)'(CAPACITY);
      end
      return PW'(sum);
   endfunction

   // Scan index look-ahead.
   assign idx1 = (CW+1)'(idx_ff) + (CW+1)'(1);
   assign idx2 = (CW+1)'(idx_ff) + (CW+1)'(2);

   // Status towards the controller.
   assign stat.op      = op_ff;
   assign stat.empty   = (count_ff == '0);
   assign stat.full    = (count_ff >= CW'(CAPACITY));
   assign stat.pos_ok  = (EW'(pos_ff) < EW'(count_ff));
   assign stat.match   = (rd_data_ff == key_ff);
   assign stat.idx1_lt = (idx1 < (CW+1)'(count_ff));
   assign stat.idx2_lt = (idx2 < (CW+1)'(count_ff));

   // Neighbouring front slots with wrap-around.
   assign front_dec = (front_ff == '0) ? PW'(CAPACITY - 1) : front_ff - PW'(1);
   assign front_inc = (front_ff == PW'(CAPACITY - 1)) ? '0 : front_ff + PW'(1);

   // Read offset selection.
   always_comb begin
      unique case (cmd.rd_sel)
         RD_FRONT: rd_off = '0;
         RD_BACK:  rd_off = count_ff - CW'(1);
         RD_POS:   rd_off = CW'(pos_ff);
         RD_IDX1:  rd_off = CW'(idx1);
         RD_IDX2:  rd_off = CW'(idx2);
         default:  rd_off = '0;
      endcase
   end
   assign rd_addr = slot_of(front_ff, rd_off);

   // Write port: pushes at either end, or one step of closing the gap on removal.
   always_comb begin
      wr_en   = cmd.push_front | cmd.push_back | cmd.shift_write;
      wr_addr = slot_of(front_ff, idx_ff);
      wr_data = rd_data_ff;
      if (cmd.push_front) begin
         wr_addr = front_dec;
         wr_data = key_ff;
      end else if (cmd.push_back) begin
         wr_addr = slot_of(front_ff, count_ff);
         wr_data = key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // Pointer, count and scan index updates.
   always_comb begin
      front_in = front_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      if (cmd.push_front) begin
         front_in = front_dec;
         count_in = count_ff + CW'(1);
      end else if (cmd.push_back) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.pop_front) begin
         front_in = front_inc;
         count_in = count_ff - CW'(1);
      end else if (cmd.dec_count) begin
         count_in = count_ff - CW'(1);
      end
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = CW'(idx1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
      idx_ff <= idx_in;
   end

   // Request word capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_opcode;
         key_ff <= VALUE_WIDTH'(req_operand_value);
         pos_ff <= req_position;
      end
   end

   // Response value selection.
   always_comb begin
      unique case (cmd.resp_sel)
         RV_ZERO:  value_in = '0;
         RV_DATA:  value_in = RESULT_W'(rd_data_ff);
         RV_KEY:   value_in = RESULT_W'(key_ff);
         RV_ONES:  value_in = '1;
         RV_COUNT: value_in = RESULT_W'(count_ff);
         default:  value_in = '0;
      endcase
   end

   // Response word registers; the strobe lasts one cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.respond;
      end
      if (cmd.respond) begin
         value_ff  <= value_in;
         status_ff <= cmd.resp_status;
         occ_ff    <= OCC_W'(count_in);
         empty_ff  <= (count_in == '0);
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_result_value = value_ff;
   assign rsp_status       = status_ff;
   assign rsp_occupancy    = occ_ff;
   assign rsp_is_empty     = empty_ff;

   // The count never exceeds the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count beyond capacity");

   // The front pointer always names a slot of the store.
   a_front_bound: assert property (@(posedge clock) disable iff (reset)
      front_ff <= PW'(CAPACITY - 1))
      else $error("front pointer outside the store");

   // A respond command is followed by a strobe.
   a_respond_strobe: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |=> rsp_strobe)
      else $error("respond command without strobe");

   // A not-found response always carries all ones.
   a_not_found_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_NOT_FOUND) |-> (rsp_result_value == '1))
      else $error("not-found response with wrong value");

endmodule

// ----- src/dqrm_control.sv -----
// Controller state machine of the deque: sequences reads, scans and gap closing.
module dqrm_control
   import dqrm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  dqrm_stat_type stat,
   output dqrm_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_SHIFT = 3'd4;

   logic [2:0] state_ff, state_in;

   assign busy = (state_ff != S_IDLE);

   // Next state and command decoding.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            unique case (stat.op)
               OP_PUSH_FRONT, OP_PUSH_BACK: begin
                  cmd.respond = 1'b1;
                  if (stat.full) begin
                     cmd.resp_status = ST_FULL;
                  end else begin
                     cmd.push_front = (stat.op == OP_PUSH_FRONT);
                     cmd.push_back  = (stat.op == OP_PUSH_BACK);
                  end
               end
               OP_POP_FRONT, OP_PEEK_FRONT, OP_POP_BACK, OP_PEEK_BACK: begin
                  if (stat.empty) begin
                     cmd.respond     = 1'b1;
                     cmd.resp_status = ST_EMPTY;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = (stat.op == OP_POP_FRONT || stat.op == OP_PEEK_FRONT)
                                  ? RD_FRONT : RD_BACK;
                     state_in   = S_READ;
                  end
               end
               OP_NTH: begin
                  if (stat.empty) begin
                     cmd.respond     = 1'b1;
                     cmd.resp_status = ST_EMPTY;
                  end else if (!stat.pos_ok) begin
                     cmd.respond     = 1'b1;
                     cmd.resp_status = ST_RANGE;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_POS;
                     state_in   = S_READ;
                  end
               end
               OP_REMOVE: begin
                  if (stat.empty) begin
                     cmd.respond     = 1'b1;
                     cmd.resp_status = ST_NOT_FOUND;
                     cmd.resp_sel    = RV_ONES;
                  end else begin
                     cmd.idx_clear = 1'b1;
                     cmd.rd_en     = 1'b1;
                     cmd.rd_sel    = RD_FRONT;
                     state_in      = S_SCAN;
                  end
               end
               OP_SIZE: begin
                  cmd.respond  = 1'b1;
                  cmd.resp_sel = RV_COUNT;
               end
               default: begin
                  cmd.respond = 1'b1;
               end
            endcase
         end
         S_READ: begin
            // Read data is now registered; pops also retire the entry.
            cmd.respond   = 1'b1;
            cmd.resp_sel  = RV_DATA;
            cmd.pop_front = (stat.op == OP_POP_FRONT);
            cmd.dec_count = (stat.op == OP_POP_BACK);
            state_in      = S_IDLE;
         end
         S_SCAN: begin
            // Compare one entry per cycle, walking from the front.
            if (stat.match) begin
               if (stat.idx1_lt) begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_IDX1;
                  state_in   = S_SHIFT;
               end else begin
                  cmd.dec_count = 1'b1;
                  cmd.respond   = 1'b1;
                  cmd.resp_sel  = RV_KEY;
                  state_in      = S_IDLE;
               end
            end else if (stat.idx1_lt) begin
               cmd.idx_inc = 1'b1;
               cmd.rd_en   = 1'b1;
               cmd.rd_sel  = RD_IDX1;
            end else begin
               cmd.respond     = 1'b1;
               cmd.resp_status = ST_NOT_FOUND;
               cmd.resp_sel    = RV_ONES;
               state_in        = S_IDLE;
            end
         end
         S_SHIFT: begin
            // Move the next entry one place towards the front each cycle.
            cmd.shift_write = 1'b1;
            cmd.idx_inc     = 1'b1;
            if (stat.idx2_lt) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_IDX2;
            end else begin
               cmd.dec_count = 1'b1;
               cmd.respond   = 1'b1;
               cmd.resp_sel  = RV_KEY;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A request is only taken from the idle state.
   a_capture_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> (state_ff == S_IDLE))
      else $error("request captured while busy");

   // Every capture leads to the execute state.
   a_capture_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == S_EXEC))
      else $error("capture not followed by execute");

   // Responding always returns the controller to idle.
   a_respond_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |=> !busy)
      else $error("still busy after responding");

endmodule

// ----- src/deque_with_remove_by_value.sv -----
// Top level of the bounded deque with remove-by-value.
// From an accepted word to its response strobe, push, size and unused opcodes pass
// through the execute state; pop, peek and nth through execute and read; and remove
// through execute, a scan of one entry per cycle from the front and, if needed, gap closing.
// One word at a time: busy is high until the response; the next start is taken in the
// strobe cycle. Reset clears the pointers and count at once; the store needs no clearing.
module deque_with_remove_by_value
   import dqrm_pkg::*;
#(
   parameter int CAPACITY    = DEF_CAPACITY,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [OPCODE_W-1:0]         req_opcode,
   input  logic signed [OPERAND_W-1:0] req_operand_value,
   input  logic [POSITION_W-1:0]       req_position,
   output logic                        rsp_strobe,
   output logic signed [RESULT_W-1:0]  rsp_result_value,
   output logic [STATUS_W-1:0]         rsp_status,
   output logic [OCC_W-1:0]            rsp_occupancy,
   output logic                        rsp_is_empty
);

   dqrm_cmd_type  cmd;
   dqrm_stat_type stat;

   // Sequencing.
   dqrm_control u_control (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // Storage and arithmetic.
   dqrm_datapath #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_opcode        (req_opcode),
      .req_operand_value (req_operand_value),
      .req_position      (req_position),
      .rsp_strobe        (rsp_strobe),
      .rsp_result_value  (rsp_result_value),
      .rsp_status        (rsp_status),
      .rsp_occupancy     (rsp_occupancy),
      .rsp_is_empty      (rsp_is_empty)
   );

endmodule
